/* design/irtx_pkg.sv */
`timescale 1ns / 1ps

package irtx_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_START  = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd13;
    localparam int         PHASE_W           = 9;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic len_step;
        logic settle_step;
        logic check_step;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_live_tick;
        logic in_short;
        logic len_to_settle;
        logic settle_end;
        logic check_more;
        logic out_full;
    } ctrl_stat_t;

endpackage

/* design/irtx_ctrl.sv */
`timescale 1ns / 1ps

module irtx_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  irtx_pkg::ctrl_stat_t  stat,
    output irtx_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_SETTLE,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (stat.in_live_tick) begin
                        state_next = S_SETTLE;
                    end else if (stat.in_short) begin
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN:    state_next = stat.len_to_settle ? S_SETTLE : S_EMIT;
            S_SETTLE: state_next = stat.settle_end ? S_EMIT : S_CHECK;
            S_CHECK:  state_next = stat.check_more ? S_SETTLE : S_EMIT;
            S_EMIT: begin
                if (!stat.out_full) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready        = (state_reg == S_IDLE);
    assign cmd.accept      = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.len_step    = (state_reg == S_LEN);
    assign cmd.settle_step = (state_reg == S_SETTLE);
    assign cmd.check_step  = (state_reg == S_CHECK);
    assign cmd.emit        = (state_reg == S_EMIT) && !stat.out_full;

endmodule

/* design/irtx_datapath.sv */
`timescale 1ns / 1ps

module irtx_datapath #(
    parameter int NUM_CODES   = 16,
    parameter int MAX_TIMINGS = 128,
    parameter int TIMING_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data,
    input  logic [1:0]            in_action,
    input  logic [3:0]            in_code_index,
    input  logic [15:0]           in_timing_us,
    input  irtx_pkg::ctrl_cmd_t   cmd,
    output irtx_pkg::ctrl_stat_t  stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [4:0]            m_fields
);

    localparam int CW     = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
    localparam int LEN_W  = $clog2(MAX_TIMINGS + 1);
    localparam int ADDR_W = $clog2(NUM_CODES * MAX_TIMINGS);
    localparam int DEPTH  = NUM_CODES * MAX_TIMINGS;
    localparam int EW     = TIMING_BITS + 2;
    localparam int PW     = irtx_pkg::PHASE_W;
    localparam logic [63:0]       TMAX      = (64'd1 << TIMING_BITS) - 64'd1;
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_TIMINGS);
    localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(MAX_TIMINGS);

    // storage
    logic [TIMING_BITS-1:0] timing_mem [DEPTH];
    logic [LEN_W-1:0]       len_mem    [NUM_CODES];
    logic [NUM_CODES-1:0]   len_valid_reg;

    // latched command
    irtx_pkg::action_t      action_reg;
    logic [CW-1:0]          idx_reg;
    logic [15:0]            tval_reg;

    // send state
    logic                   sending_reg;
    logic [CW-1:0]          active_reg;
    logic [LEN_W-1:0]       active_len_reg;
    logic [LEN_W-1:0]       pos_reg;
    logic                   in_space_reg;
    logic [EW-1:0]          elapsed_reg;
    logic [PW-1:0]          phase_reg;
    logic [7:0]             half_reg;

    // read data and result under construction
    logic [TIMING_BITS-1:0] rd_reg;
    logic [LEN_W-1:0]       len_rd_reg;
    logic                   len_vld_rd_reg;
    logic                   res_led_reg;
    logic                   res_done_reg;
    logic                   res_odd_reg;
    logic                   res_rej_reg;
    logic                   out_valid_reg;
    logic [4:0]             out_data_reg;

    logic                   in_tick;
    logic                   in_range;
    logic [CW-1:0]          in_idx;
    logic [LEN_W-1:0]       cur_len;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [TIMING_BITS-1:0] sat_timing;
    logic [PW-1:0]          half_eff;
    logic [PW-1:0]          phase_inc;
    logic                   tick_led;
    logic                   has_next;
    logic                   advance;

    assign in_tick  = (in_action == irtx_pkg::ACT_TICK);
    assign in_range = (9'(in_code_index) < 9'(NUM_CODES));
    assign in_idx   = CW'(in_code_index);
    assign cur_len  = len_vld_rd_reg ? len_rd_reg : '0;

    assign wr_addr  = ADDR_W'(idx_reg) * ROW_SIZE + ADDR_W'(cur_len);
    assign rd_addr  = ADDR_W'(active_reg) * ROW_SIZE + ADDR_W'(pos_reg);

    assign sat_timing = (64'(tval_reg) > TMAX) ? TMAX[TIMING_BITS-1:0]
                                               : TIMING_BITS'(tval_reg);

    // a half period of zero behaves as one
    assign half_eff  = (half_reg == 8'd0) ? PW'(1) : PW'(half_reg);
    assign phase_inc = phase_reg + PW'(1);
    assign tick_led  = !in_space_reg && (phase_reg < half_eff);

    assign has_next = ((LEN_W + 1)'(pos_reg) + (LEN_W + 1)'(1)) < (LEN_W + 1)'(active_len_reg);
    // marks end only on a carrier period boundary
    assign advance  = (in_space_reg || (phase_reg == '0)) && (elapsed_reg >= EW'(rd_reg));

    assign stat.in_live_tick  = in_tick && sending_reg;
    assign stat.in_short      = in_tick || sending_reg || !in_range;
    assign stat.len_to_settle = (action_reg == irtx_pkg::ACT_START) && (cur_len < LEN_MAX ||
                                cur_len == LEN_MAX);
    assign stat.settle_end    = !sending_reg || (pos_reg >= active_len_reg);
    assign stat.check_more    = advance && has_next;
    assign stat.out_full      = out_valid_reg && !m_tready;

    // timing memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.len_step && (action_reg == irtx_pkg::ACT_APPEND) && (cur_len < LEN_MAX)) begin
            timing_mem[wr_addr] <= sat_timing;
        end
        rd_reg <= timing_mem[rd_addr];
    end

    // code length memory, the valid bits stand for the reset value of zero
    always_ff @(posedge aclk) begin
        if (cmd.len_step && (action_reg == irtx_pkg::ACT_APPEND) && (cur_len < LEN_MAX)) begin
            len_mem[idx_reg] <= cur_len + LEN_W'(1);
        end
        len_rd_reg <= len_mem[in_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_valid_reg  <= '0;
            len_vld_rd_reg <= 1'b0;
        end else begin
            len_vld_rd_reg <= len_valid_reg[in_idx];
            if (cmd.len_step && (action_reg == irtx_pkg::ACT_CLEAR)) begin
                len_valid_reg[idx_reg] <= 1'b0;
            end else if (cmd.len_step && (action_reg == irtx_pkg::ACT_APPEND) &&
                         (cur_len < LEN_MAX)) begin
                len_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            action_reg <= irtx_pkg::action_t'(in_action);
            idx_reg    <= in_idx;
            tval_reg   <= in_timing_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= irtx_pkg::HALF_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            half_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg    <= 1'b0;
            active_reg     <= '0;
            active_len_reg <= '0;
            pos_reg        <= '0;
            in_space_reg   <= 1'b0;
            elapsed_reg    <= '0;
            phase_reg      <= '0;
            res_led_reg    <= 1'b0;
            res_done_reg   <= 1'b0;
            res_odd_reg    <= 1'b0;
            res_rej_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                res_led_reg  <= in_tick && sending_reg && tick_led;
                res_done_reg <= 1'b0;
                res_odd_reg  <= 1'b0;
                res_rej_reg  <= !in_tick && (sending_reg || !in_range);
                if (in_tick && sending_reg) begin
                    elapsed_reg <= elapsed_reg + EW'(1);
                    if (!in_space_reg) begin
                        if ((PW + 1)'(phase_inc) >= ((PW + 1)'(half_eff) << 1)) begin
                            phase_reg <= '0;
                        end else begin
                            phase_reg <= phase_inc;
                        end
                    end
                end
            end

            if (cmd.len_step) begin
                case (action_reg)
                    irtx_pkg::ACT_APPEND: begin
                        if (cur_len >= LEN_MAX) begin
                            res_rej_reg <= 1'b1;
                        end
                    end
                    irtx_pkg::ACT_START: begin
                        sending_reg    <= 1'b1;
                        active_reg     <= idx_reg;
                        active_len_reg <= cur_len;
                        pos_reg        <= '0;
                        in_space_reg   <= 1'b0;
                        elapsed_reg    <= '0;
                        phase_reg      <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // ran off the end of the code
            if (cmd.settle_step && sending_reg && (pos_reg >= active_len_reg)) begin
                sending_reg  <= 1'b0;
                res_done_reg <= 1'b1;
                res_odd_reg  <= 1'b0;
            end

            if (cmd.check_step && advance) begin
                if (has_next) begin
                    pos_reg      <= pos_reg + LEN_W'(1);
                    elapsed_reg  <= '0;
                    in_space_reg <= !in_space_reg;
                    phase_reg    <= '0;
                end else begin
                    sending_reg  <= 1'b0;
                    res_done_reg <= 1'b1;
                    res_odd_reg  <= !in_space_reg;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {res_rej_reg, res_odd_reg, res_done_reg, sending_reg, res_led_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_fields = out_data_reg;

endmodule

/* design/ir_raw_timing_transmitter_core.sv */
`timescale 1ns / 1ps

// IR raw mark/space transmitter. Holds NUM_CODES codes of up to MAX_TIMINGS
// microsecond timings each and plays one back as carrier-modulated marks and
// plain spaces, one word per microsecond tick. Every input word gives exactly
// one result word. Words are handled one at a time: an idle tick or a refused
// command goes from idle to emit, clear and append pass the length state, a
// send tick passes settle and check, and start passes length, settle and check
// (no check for an empty code). Each step past a used-up timing repeats settle
// and check, because the next timing comes from the registered timing memory
// read. The output register lets the next word in while a result still waits.
// There is no clearing pass after reset.
module ir_raw_timing_transmitter_core #(
    parameter int NUM_CODES   = 16,
    parameter int MAX_TIMINGS = 128,
    parameter int TIMING_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // carrier_half_period
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // code_index[3:0], timing_us[19:4], zero pad
    input  logic [1:0]  s_tuser,       // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // led_level, busy_res, send_done, odd_timings,
                                       // rejected, zero pad
);

    irtx_pkg::ctrl_cmd_t  cmd;
    irtx_pkg::ctrl_stat_t stat;
    logic [4:0]           m_fields;

    irtx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    irtx_datapath #(
        .NUM_CODES   (NUM_CODES),
        .MAX_TIMINGS (MAX_TIMINGS),
        .TIMING_BITS (TIMING_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_action     (s_tuser),
        .in_code_index (s_tdata[3:0]),
        .in_timing_us  (s_tdata[19:4]),
        .cmd           (cmd),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_fields      (m_fields)
    );

    assign m_tdata = {3'b000, m_fields};

    // odd ending is only reported with the finish
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("odd_timings without send_done");

    // a finished send is no longer busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("send_done while still busy");

    // a refused command neither drives the led nor finishes a send
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[0] && !m_tdata[2])
        else $error("rejected word carries led or done");

    // a new word is taken only after the previous result is queued
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted back to back");

endmodule
